[rtl/tmcg_pkg.sv]
// Shared types, sizes and reset tables for the text-mode character generator.
`default_nettype none
package tmcg_pkg;

	// Screen and text geometry
	localparam int TEXT_COLUMNS    = 64;
	localparam int TEXT_ROWS       = 36;
	localparam int GLYPH_HEIGHT    = 8;
	localparam int SCREEN_WIDTH    = 512;
	localparam int SCREEN_HEIGHT   = 288;
	localparam int PALETTE_ENTRIES = 16;

	localparam int CELL_COUNT  = TEXT_COLUMNS * TEXT_ROWS;
	localparam int GLYPH_COUNT = 256 * GLYPH_HEIGHT;

	// Field and index widths
	localparam int KIND_W   = 3;
	localparam int ADDR_W   = 12;
	localparam int DATA_W   = 32;
	localparam int COORD_W  = 9;
	localparam int BYTE_W   = 8;
	localparam int CELL_AW  = $clog2(CELL_COUNT);
	localparam int GLYPH_AW = $clog2(GLYPH_COUNT);
	localparam int LINE_W   = $clog2(GLYPH_HEIGHT);
	localparam int PAL_W    = $clog2(PALETTE_ENTRIES);

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [DATA_W-1:0] OPAQUE_BLACK = 32'hFF000000;

	// Word kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_PIXEL  = 3'd0,
		KIND_CHAR   = 3'd1,
		KIND_ATTR   = 3'd2,
		KIND_GLYPH  = 3'd3,
		KIND_FG_PAL = 3'd4,
		KIND_BG_PAL = 3'd5
	} kind_t;

	typedef logic [DATA_W-1:0] color_t;

	// Default sixteen color palette
	localparam color_t DEFAULT_COLORS [16] = '{
		32'hFFFFFFFF, 32'hFF000000, 32'hFFD0D0D0, 32'hFFA0A0A0,
		32'hFF100B9B, 32'hFF00A024, 32'hFF00A09F, 32'hFFA8000E,
		32'hFFA9039C, 32'hFFA64A16, 32'hFF4F4DF8, 32'hFF00FF5D,
		32'hFF06FFFE, 32'hFFFF494E, 32'hFFFF4BF9, 32'hFFFEFE60
	};

	// Background reset: white and black trade places
	function automatic color_t bg_default(input int idx);
		color_t c;
		if (idx == 0) begin
			c = DEFAULT_COLORS[1];
		end else if (idx == 1) begin
			c = DEFAULT_COLORS[0];
		end else begin
			c = DEFAULT_COLORS[idx];
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/tmcg_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module tmcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule
`default_nettype wire

[rtl/text_mode_character_generator_top.sv]
// Pixel path: a result word goes through the stage 1 and stage 2 registers into the result queue.
// Throughput: one word per cycle while req_stall is low; char/attr read at accept, glyph and
// palettes in the cycle after, color select into a four-entry result queue.
// Reset: palettes load defaults at once; a sweep over all 2304 cells then zeroes the
// character and attribute stores, with req_stall held high until it ends.
`default_nettype none
module text_mode_character_generator_top
	import tmcg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [ADDR_W-1:0]  address,
	input  wire logic [DATA_W-1:0]  write_data,
	input  wire logic [COORD_W-1:0] pixel_x,
	input  wire logic [COORD_W-1:0] pixel_y,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic      [DATA_W-1:0]  pixel_color
);

	logic               accept;
	logic               pix_acc;
	logic               blank;
	logic [CELL_AW-1:0] cell_addr;

	logic               clearing_q;
	logic [CELL_AW-1:0] clr_cnt_q;

	logic                char_we, attr_we, glyph_we;
	logic [CELL_AW-1:0]  cell_waddr, cell_raddr;
	logic [BYTE_W-1:0]   char_wdata, attr_wdata;
	logic [BYTE_W-1:0]   code, attr, glyph;
	logic [GLYPH_AW-1:0] glyph_raddr;

	color_t fg_pal_q [PALETTE_ENTRIES];
	color_t bg_pal_q [PALETTE_ENTRIES];

	logic              v_s1, blank_s1;
	logic [LINE_W-1:0] line_s1;
	logic [2:0]        bit_s1;
	logic              v_s2, blank_s2;
	logic [2:0]        bit_s2;
	color_t            fg_s2, bg_s2;
	color_t            color;

	color_t             fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               push, pop;
	logic [FIFO_CW+1:0] pending;

	// Handshake and credit: every pixel in flight has a queue slot reserved
	assign pending   = (FIFO_CW+2)'(count_q) + (FIFO_CW+2)'(v_s1) + (FIFO_CW+2)'(v_s2);
	assign req_stall = clearing_q || (pending >= (FIFO_CW+2)'(FIFO_DEPTH));
	assign accept    = req_valid && !req_stall;
	assign pix_acc   = accept && (kind == KIND_PIXEL);

	// Cell lookup from the requested coordinates
	always_comb begin
		blank = (32'(pixel_x) >= 32'(SCREEN_WIDTH)) ||
			(32'(pixel_y) >= 32'(SCREEN_HEIGHT)) ||
			(32'(pixel_x) >= 32'(TEXT_COLUMNS * 8)) ||
			(32'(pixel_y) >= 32'(TEXT_ROWS * GLYPH_HEIGHT));
		cell_addr = CELL_AW'((32'(pixel_y) / GLYPH_HEIGHT) * TEXT_COLUMNS +
			32'(pixel_x >> 3));
	end

	// Clearing sweep over the cell stores after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CELL_AW'(CELL_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Cell store ports: sweep writes zeros, otherwise writes land at accept
	always_comb begin
		cell_raddr = blank ? '0 : cell_addr;
		if (clearing_q) begin
			char_we    = 1'b1;
			attr_we    = 1'b1;
			cell_waddr = clr_cnt_q;
			char_wdata = '0;
			attr_wdata = '0;
		end else begin
			char_we    = accept && (kind == KIND_CHAR) && (32'(address) < 32'(CELL_COUNT));
			attr_we    = accept && (kind == KIND_ATTR) && (32'(address) < 32'(CELL_COUNT));
			cell_waddr = CELL_AW'(address);
			char_wdata = write_data[BYTE_W-1:0];
			attr_wdata = write_data[BYTE_W-1:0];
		end
	end

	tmcg_ram #(.WIDTH(BYTE_W), .DEPTH(CELL_COUNT)) u_char_ram (
		.clk   (clk),
		.we    (char_we),
		.waddr (cell_waddr),
		.wdata (char_wdata),
		.raddr (cell_raddr),
		.rdata (code)
	);

	tmcg_ram #(.WIDTH(BYTE_W), .DEPTH(CELL_COUNT)) u_attr_ram (
		.clk   (clk),
		.we    (attr_we),
		.waddr (cell_waddr),
		.wdata (attr_wdata),
		.raddr (cell_raddr),
		.rdata (attr)
	);

	// Glyph store: row byte of the code read in the cycle after accept
	assign glyph_we    = accept && (kind == KIND_GLYPH) && (32'(address) < 32'(GLYPH_COUNT));
	assign glyph_raddr = GLYPH_AW'(32'(code) * GLYPH_HEIGHT + 32'(line_s1));

	tmcg_ram #(.WIDTH(BYTE_W), .DEPTH(GLYPH_COUNT)) u_glyph_ram (
		.clk   (clk),
		.we    (glyph_we),
		.waddr (GLYPH_AW'(address)),
		.wdata (write_data[BYTE_W-1:0]),
		.raddr (glyph_raddr),
		.rdata (glyph)
	);

	// Palettes: written at accept, read in stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PALETTE_ENTRIES; i++) begin
				fg_pal_q[i] <= DEFAULT_COLORS[i];
				bg_pal_q[i] <= bg_default(i);
			end
		end else if (accept && (32'(address) < 32'(PALETTE_ENTRIES))) begin
			if (kind == KIND_FG_PAL) begin
				fg_pal_q[PAL_W'(address)] <= write_data;
			end
			if (kind == KIND_BG_PAL) begin
				bg_pal_q[PAL_W'(address)] <= write_data;
			end
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= pix_acc;
			v_s2 <= v_s1;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		blank_s1 <= blank;
		line_s1  <= LINE_W'(32'(pixel_y) % GLYPH_HEIGHT);
		bit_s1   <= pixel_x[2:0];
		blank_s2 <= blank_s1;
		bit_s2   <= bit_s1;
		fg_s2    <= fg_pal_q[PAL_W'(32'(attr[3:0]) % PALETTE_ENTRIES)];
		bg_s2    <= bg_pal_q[PAL_W'(32'(attr[7:4]) % PALETTE_ENTRIES)];
	end

	// Color select: leftmost pixel is the glyph's top bit
	assign color = blank_s2 ? OPAQUE_BLACK : (glyph[3'd7 - bit_s2] ? fg_s2 : bg_s2);

	// Result queue
	assign push        = v_s2;
	assign pop         = rsp_valid && !rsp_stall;
	assign rsp_valid   = (count_q != '0);
	assign pixel_color = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= color;
		end
	end

`ifndef SYNTHESIS
	// Reserved slots never exceed the queue
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pending <= (FIFO_CW+2)'(FIFO_DEPTH))
		else $error("result queue overcommitted");

	// A push never meets a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < FIFO_CW'(FIFO_DEPTH)))
		else $error("push into full result queue");

	// An accepted pixel reaches the color stage through the stage 1 and stage 2 valid registers
	a_pix_flow: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc |=> ##1 v_s2)
		else $error("pixel lost in pipeline");

	// No word is taken while the cell stores are being cleared
	a_clear_hold: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !accept)
		else $error("word accepted during clearing sweep");
`endif

endmodule
`default_nettype wire
